>>> design/hrhf_pkg.sv
// Shared types and constants for the HTTP request head framer.
package hrhf_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  verdict_t;
  typedef logic [2:0]  pstate_t;
  typedef logic [15:0] count_t;

  // Recogniser states
  localparam pstate_t ST_METHOD  = 3'd0;
  localparam pstate_t ST_SP1     = 3'd1;
  localparam pstate_t ST_URI     = 3'd2;
  localparam pstate_t ST_SP2     = 3'd3;
  localparam pstate_t ST_VERSION = 3'd4;
  localparam pstate_t ST_LF      = 3'd5;
  localparam pstate_t ST_LINE    = 3'd6;

  // Verdict codes
  localparam verdict_t V_INCOMPLETE = 2'd0;
  localparam verdict_t V_COMPLETE   = 2'd1;
  localparam verdict_t V_INVALID    = 2'd2;

  // Characters of interest
  localparam byte_t CH_SP  = 8'h20;
  localparam byte_t CH_CR  = 8'h0D;
  localparam byte_t CH_LF  = 8'h0A;
  localparam byte_t CH_TAB = 8'h09;

  localparam longint unsigned COUNT_MAX = 64'd65535;

endpackage

>>> design/hrhf_if.sv
// Valid/ready channel interfaces for received bytes and framing results.
interface hrhf_in_if;
  logic             valid;
  logic             ready;
  hrhf_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hrhf_out_if;
  logic               valid;
  logic               ready;
  hrhf_pkg::verdict_t verdict;
  logic               old_style;
  hrhf_pkg::count_t   head_length;

  modport source (output valid, output verdict, output old_style, output head_length,
                  input ready);
  modport sink   (input valid, input verdict, input old_style, input head_length,
                  output ready);
endinterface

>>> design/http_request_head_framer_unit.sv
// HTTP request head framer: per-byte recogniser with registered result word.
// The result for a byte is registered and shown in the cycle after the byte is taken.
// Throughput: one byte per cycle while a pending result word is taken; the state
// register and the byte counter are updated in the accepting cycle, and the result register drains in parallel.
// Reset (synchronous, rst_n low): recogniser to the method state, count to
// zero, result register emptied.
module http_request_head_framer_unit #(
  parameter longint unsigned MAX_HEAD_BYTES = 65535
) (
  input  logic                clk,
  input  logic                rst_n,
  hrhf_in_if.sink             in_ch,
  hrhf_out_if.source          out_ch
);

  localparam longint unsigned CAP =
    (MAX_HEAD_BYTES < hrhf_pkg::COUNT_MAX) ? MAX_HEAD_BYTES : hrhf_pkg::COUNT_MAX;
  localparam hrhf_pkg::count_t CAP16 = hrhf_pkg::count_t'(CAP);

  hrhf_pkg::pstate_t  parse_state_r, parse_state_nxt, st_next;
  hrhf_pkg::count_t   byte_count_r, byte_count_nxt, cnt_inc;
  logic               out_valid_r, out_valid_nxt;
  hrhf_pkg::verdict_t verdict_r, verdict_nxt, verdict_c;
  logic               old_style_r, old_style_nxt, old_c;
  hrhf_pkg::count_t   head_length_r, head_length_nxt;
  logic               in_fire;
  logic               is_letter;
  hrhf_pkg::byte_t    c;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign c           = in_ch.rx_byte;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = verdict_r;
  assign out_ch.old_style   = old_style_r;
  assign out_ch.head_length = head_length_r;

  // Saturate at the cap and hold
  assign cnt_inc = (byte_count_r >= CAP16) ? CAP16 : byte_count_r + 16'd1;

  always_comb begin
    is_letter = (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    st_next   = parse_state_r;
    verdict_c = hrhf_pkg::V_INCOMPLETE;
    old_c     = 1'b0;
    case (parse_state_r)
      hrhf_pkg::ST_SP1, hrhf_pkg::ST_SP2: begin
        if (c == hrhf_pkg::CH_SP) begin
          st_next = parse_state_r;
        end else if (c == hrhf_pkg::CH_CR || c == hrhf_pkg::CH_LF ||
                     c == hrhf_pkg::CH_TAB) begin
          verdict_c = hrhf_pkg::V_INVALID;
        end else begin
          st_next = (parse_state_r == hrhf_pkg::ST_SP1) ? hrhf_pkg::ST_URI
                                                        : hrhf_pkg::ST_VERSION;
        end
      end
      hrhf_pkg::ST_URI: begin
        if (c == hrhf_pkg::CH_LF) begin
          verdict_c = hrhf_pkg::V_COMPLETE;
          old_c     = 1'b1;
        end else if (c == hrhf_pkg::CH_SP) begin
          st_next = hrhf_pkg::ST_SP2;
        end else if (c == hrhf_pkg::CH_TAB) begin
          verdict_c = hrhf_pkg::V_INVALID;
        end
      end
      hrhf_pkg::ST_VERSION: begin
        if (c == hrhf_pkg::CH_LF) begin
          st_next = hrhf_pkg::ST_LF;
        end else if (c == hrhf_pkg::CH_SP || c == hrhf_pkg::CH_TAB) begin
          verdict_c = hrhf_pkg::V_INVALID;
        end
      end
      hrhf_pkg::ST_LF: begin
        if (c == hrhf_pkg::CH_LF) begin
          verdict_c = hrhf_pkg::V_COMPLETE;
        end else if (c != hrhf_pkg::CH_CR) begin
          st_next = hrhf_pkg::ST_LINE;
        end
      end
      hrhf_pkg::ST_LINE: begin
        if (c == hrhf_pkg::CH_LF) begin
          st_next = hrhf_pkg::ST_LF;
        end
      end
      default: begin
        // method word; the unused code behaves the same
        if (c == hrhf_pkg::CH_SP) begin
          st_next = hrhf_pkg::ST_SP1;
        end else if (!is_letter) begin
          verdict_c = hrhf_pkg::V_INVALID;
        end else begin
          st_next = hrhf_pkg::ST_METHOD;
        end
      end
    endcase
  end

  always_comb begin
    parse_state_nxt = parse_state_r;
    byte_count_nxt  = byte_count_r;
    out_valid_nxt   = out_valid_r;
    verdict_nxt     = verdict_r;
    old_style_nxt   = old_style_r;
    head_length_nxt = head_length_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt   = 1'b1;
      verdict_nxt     = verdict_c;
      old_style_nxt   = old_c;
      head_length_nxt = cnt_inc;
      // Start a new request after a complete or invalid verdict
      if (verdict_c != hrhf_pkg::V_INCOMPLETE) begin
        parse_state_nxt = hrhf_pkg::ST_METHOD;
        byte_count_nxt  = '0;
      end else begin
        parse_state_nxt = st_next;
        byte_count_nxt  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_state_r <= hrhf_pkg::ST_METHOD;
      byte_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      parse_state_r <= parse_state_nxt;
      byte_count_r  <= byte_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r     <= verdict_nxt;
    old_style_r   <= old_style_nxt;
    head_length_r <= head_length_nxt;
  end

`ifndef SYNTHESIS
  a_old_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && old_style_r) |-> (verdict_r == hrhf_pkg::V_COMPLETE))
    else $error("old_style set without a complete verdict");

  a_restart_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && verdict_c != hrhf_pkg::V_INCOMPLETE)
      |=> (parse_state_r == hrhf_pkg::ST_METHOD && byte_count_r == '0))
    else $error("recogniser not restarted after a verdict");

  a_count_capped: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= CAP16)
    else $error("byte count beyond cap");

  a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (head_length_r != '0))
    else $error("result word with zero length");

  a_count_tracks_length: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && verdict_c == hrhf_pkg::V_INCOMPLETE) |=> (byte_count_r == head_length_r))
    else $error("byte count and reported length disagree");
`endif

endmodule

>>> verif/tb.sv
// Testbench for the HTTP request head framer: directed and random byte streams checked per word.
`timescale 1ns / 100ps

module tb;

  localparam longint unsigned HEAD_MAX = 65535;
  localparam longint unsigned HEAD_CAP =
    (HEAD_MAX < hrhf_pkg::COUNT_MAX) ? HEAD_MAX : hrhf_pkg::COUNT_MAX;

  typedef struct packed {
    hrhf_pkg::verdict_t verdict;
    logic               old_style;
    hrhf_pkg::count_t   head_length;
  } framing_t;

  logic clk;
  logic rst_n;

  hrhf_in_if  in_ch();
  hrhf_out_if out_ch();

  http_request_head_framer_unit #(
    .MAX_HEAD_BYTES(HEAD_MAX)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  framing_t          expected_framing[$];
  hrhf_pkg::pstate_t frame_state = hrhf_pkg::ST_METHOD;
  hrhf_pkg::count_t  head_count = '0;
  int                fail_count = 0;
  int                bytes_sent = 0;
  int                hold_off_cycles = 0;
  bit                src_idle_on = 1'b1;
  bit                sink_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** http_request_head_framer_unit: FAILED **");
    $finish;
  end

  // Framing of one byte: returns the expected word and advances the recogniser.
  function automatic framing_t frame_byte(input hrhf_pkg::byte_t b);
    framing_t          r;
    hrhf_pkg::pstate_t nxt;
    longint unsigned   n;
    nxt         = frame_state;
    r.verdict   = hrhf_pkg::V_INCOMPLETE;
    r.old_style = 1'b0;
    n = longint'(head_count) + 1;
    if (n > HEAD_CAP) n = HEAD_CAP;
    case (frame_state)
      hrhf_pkg::ST_SP1, hrhf_pkg::ST_SP2: begin
        if (b != hrhf_pkg::CH_SP) begin
          if (b == hrhf_pkg::CH_CR || b == hrhf_pkg::CH_LF || b == hrhf_pkg::CH_TAB) begin
            r.verdict = hrhf_pkg::V_INVALID;
          end else begin
            nxt = (frame_state == hrhf_pkg::ST_SP1) ? hrhf_pkg::ST_URI
                                                    : hrhf_pkg::ST_VERSION;
          end
        end
      end
      hrhf_pkg::ST_URI: begin
        if (b == hrhf_pkg::CH_LF) begin
          r.verdict   = hrhf_pkg::V_COMPLETE;
          r.old_style = 1'b1;
        end else if (b == hrhf_pkg::CH_SP) begin
          nxt = hrhf_pkg::ST_SP2;
        end else if (b == hrhf_pkg::CH_TAB) begin
          r.verdict = hrhf_pkg::V_INVALID;
        end
      end
      hrhf_pkg::ST_VERSION: begin
        if (b == hrhf_pkg::CH_LF) nxt = hrhf_pkg::ST_LF;
        else if (b == hrhf_pkg::CH_SP || b == hrhf_pkg::CH_TAB) r.verdict = hrhf_pkg::V_INVALID;
      end
      hrhf_pkg::ST_LF: begin
        if (b == hrhf_pkg::CH_LF) r.verdict = hrhf_pkg::V_COMPLETE;
        else if (b != hrhf_pkg::CH_CR) nxt = hrhf_pkg::ST_LINE;
      end
      hrhf_pkg::ST_LINE: begin
        if (b == hrhf_pkg::CH_LF) nxt = hrhf_pkg::ST_LF;
      end
      default: begin
        if (b == hrhf_pkg::CH_SP) begin
          nxt = hrhf_pkg::ST_SP1;
        end else if (!((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))) begin
          r.verdict = hrhf_pkg::V_INVALID;
        end else begin
          nxt = hrhf_pkg::ST_METHOD;
        end
      end
    endcase
    r.head_length = hrhf_pkg::count_t'(n);
    if (r.verdict != hrhf_pkg::V_INCOMPLETE) begin
      frame_state = hrhf_pkg::ST_METHOD;
      head_count  = '0;
    end else begin
      frame_state = nxt;
      head_count  = hrhf_pkg::count_t'(n);
    end
    return r;
  endfunction

  task automatic send_byte(input hrhf_pkg::byte_t b);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_framing.push_back(frame_byte(b));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Corrupt the odd byte of a noisy request, favouring the separators.
  task automatic send_field(input hrhf_pkg::byte_t b, input bit noisy);
    if (noisy && $urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 5))
        0: b = hrhf_pkg::CH_CR;
        1: b = hrhf_pkg::CH_LF;
        2: b = hrhf_pkg::CH_TAB;
        3: b = hrhf_pkg::CH_SP;
        default: b = hrhf_pkg::byte_t'($urandom_range(0, 255));
      endcase
    end
    send_byte(b);
  endtask

  // Word byte for a URI or version: never a separator; CR only past the first byte.
  function automatic hrhf_pkg::byte_t pick_word_byte(input bit first);
    hrhf_pkg::byte_t b;
    do begin
      if ($urandom_range(0, 3) == 0) b = hrhf_pkg::byte_t'($urandom_range(0, 255));
      else b = hrhf_pkg::byte_t'($urandom_range(33, 126));
    end while (b == hrhf_pkg::CH_SP || b == hrhf_pkg::CH_TAB || b == hrhf_pkg::CH_LF ||
               (first && b == hrhf_pkg::CH_CR));
    return b;
  endfunction

  task automatic send_random_request();
    bit              noisy;
    int              k;
    hrhf_pkg::byte_t b;
    noisy        = ($urandom_range(0, 4) == 0);
    src_idle_on  = ($urandom_range(0, 3) != 0);
    sink_idle_on = ($urandom_range(0, 3) != 0);
    repeat ($urandom_range(1, 6)) begin
      k = $urandom_range(0, 51);
      send_field((k < 26) ? hrhf_pkg::byte_t'("A" + k) : hrhf_pkg::byte_t'("a" + k - 26),
                 noisy);
    end
    repeat ($urandom_range(1, 3)) send_field(hrhf_pkg::CH_SP, noisy);
    k = $urandom_range(1, 8);
    for (int i = 0; i < k; i++) send_field(pick_word_byte(i == 0), noisy);
    if ($urandom_range(0, 3) == 0) begin
      send_field(hrhf_pkg::CH_LF, noisy);
    end else begin
      repeat ($urandom_range(1, 3)) send_field(hrhf_pkg::CH_SP, noisy);
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) send_field(pick_word_byte(i == 0), noisy);
      send_field(hrhf_pkg::CH_LF, noisy);
      repeat ($urandom_range(0, 3)) begin
        k = $urandom_range(1, 10);
        for (int i = 0; i < k; i++) begin
          do begin
            if ($urandom_range(0, 3) == 0) b = hrhf_pkg::byte_t'($urandom_range(0, 255));
            else b = hrhf_pkg::byte_t'($urandom_range(32, 126));
          end while (b == hrhf_pkg::CH_LF);
          send_field(b, noisy);
        end
        if ($urandom_range(0, 1) == 0) send_field(hrhf_pkg::CH_CR, noisy);
        send_field(hrhf_pkg::CH_LF, noisy);
      end
      repeat ($urandom_range(0, 2)) send_field(hrhf_pkg::CH_CR, noisy);
      send_field(hrhf_pkg::CH_LF, noisy);
    end
  endtask

  task automatic test_complete_requests();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    send_text("A B\n");
    send_text("z b c\nH\n\r\n");
  endtask

  task automatic test_invalid_bytes();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("A \t");
    send_text("A ");
    send_byte(8'hFF);
    send_byte(hrhf_pkg::CH_TAB);
  endtask

  task automatic test_random_stream();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 700) send_random_request();
  endtask

  task automatic test_backpressure();
    src_idle_on     = 1'b0;
    sink_idle_on    = 1'b1;
    hold_off_cycles = 60;
    send_text("POST /index.html HTTP/1.1\nHost: x\n\n");
    sink_idle_on = 1'b0;
    send_text("GET /a HTTP/1.0\r\n\r\n");
  endtask

  task automatic test_long_head();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_text("A / H\n");
    repeat (300) send_byte("x");
    send_text("\n\n");
    send_text("A B\n");
  endtask

  initial begin : result_sink
    int       gap;
    framing_t exp_word;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        gap = sink_idle_on ? $urandom_range(0, 7) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (expected_framing.size() == 0) begin
        $error("result word with nothing expected: verdict %0d", out_ch.verdict);
        fail_count++;
      end else begin
        exp_word = expected_framing.pop_front();
        if (out_ch.verdict !== exp_word.verdict) begin
          $error("verdict: expected %0d, actual %0d", exp_word.verdict, out_ch.verdict);
          fail_count++;
        end
        if (out_ch.old_style !== exp_word.old_style) begin
          $error("old_style: expected %0d, actual %0d", exp_word.old_style, out_ch.old_style);
          fail_count++;
        end
        if (out_ch.head_length !== exp_word.head_length) begin
          $error("head_length: expected %0d, actual %0d",
                 exp_word.head_length, out_ch.head_length);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int guard;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_complete_requests();
    test_invalid_bytes();
    test_random_stream();
    test_backpressure();
    test_long_head();

    in_ch.valid <= 1'b0;
    guard = 0;
    while (expected_framing.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (expected_framing.size() != 0) begin
      $error("%0d expected result words never arrived", expected_framing.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** http_request_head_framer_unit: PASSED **");
    end else begin
      $display("** http_request_head_framer_unit: FAILED **");
    end
    $finish;
  end

endmodule
